@@ rtl/opt_pkg.sv @@
`default_nettype none

package opt_pkg;

  // Operation codes carried by an input item.
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NOP    = 2'd3
  } opcode_t;

  // Result codes.
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NO_MATCH = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // Bounds are kept two bits wider than a coordinate so that x +/- range never wraps.
  localparam int BOUND_GUARD_BITS = 2;

endpackage

`default_nettype wire

@@ rtl/obstacle_point_table_core.sv @@
`default_nettype none

// Obstacle point table. Each item carries one operation on a table of up to
// TABLE_ENTRIES points: insert into the lowest free slot, delete one exact
// match, or query whether any stored point lies in the closed square of
// half-width search_range around the given point. Every item yields exactly
// one status, shown for one cycle while done is high; the receiver cannot
// stall the block and must take the status in that cycle. An item is taken
// when start is high and busy is low. Items pass through a one-item input
// register and a two-entry queue before the execution unit, so a few items
// can be taken while an earlier one is still being carried out. The
// execution unit walks the table one slot per cycle: a delete or a query
// reads up to all TABLE_ENTRIES slots and stops at the first hit, an insert
// steps over the occupied slots below the first free one, and an insert into
// a full table, a delete or query on an empty table and the unused opcode
// end without a walk. When the execution unit is idle, an accepted item
// passes through the input register and the queue before execution starts,
// and the status is registered. The sustained rate is therefore set by the
// slot walk through the point memory.
module obstacle_point_table_core import opt_pkg::*; #(
  parameter int TABLE_ENTRIES = 64,
  parameter int COORD_BITS    = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            opcode,
  input  wire logic [COORD_BITS-1:0] x_coord,
  input  wire logic [COORD_BITS-1:0] y_coord,
  input  wire logic [COORD_BITS-2:0] search_range,
  output logic                       done,
  output logic [1:0]                 status
);

  // A queued command holds the opcode, the raw point and the four query bounds.
  localparam int CMD_W = 2 + 2 * COORD_BITS + 4 * (COORD_BITS + BOUND_GUARD_BITS);

  logic             queue_full;
  logic             queue_empty;
  logic             push;
  logic             pop;
  logic [CMD_W-1:0] front_cmd;
  logic [CMD_W-1:0] back_cmd;

  // The front register takes items and works out the query bounds.
  opt_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .search_range (search_range),
    .queue_full   (queue_full),
    .push         (push),
    .cmd          (front_cmd)
  );

  // The queue lets the front keep taking items while the back walks the table.
  opt_fifo #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_cmd),
    .pop   (pop),
    .dout  (back_cmd),
    .empty (queue_empty),
    .full  (queue_full)
  );

  // The back holds the table and carries out one command at a time.
  opt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .COORD_BITS    (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .cmd         (back_cmd),
    .pop         (pop),
    .done        (done),
    .status      (status)
  );

endmodule

`default_nettype wire

@@ rtl/opt_ram.sv @@
`default_nettype none

module opt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/opt_front.sv @@
`default_nettype none

module opt_front import opt_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            opcode,
  input  wire logic [COORD_BITS-1:0] x_coord,
  input  wire logic [COORD_BITS-1:0] y_coord,
  input  wire logic [COORD_BITS-2:0] search_range,
  input  wire logic                  queue_full,
  output logic                       push,
  output logic [2+2*COORD_BITS+4*(COORD_BITS+BOUND_GUARD_BITS)-1:0] cmd
);

  localparam int BW = COORD_BITS + BOUND_GUARD_BITS;

  typedef struct packed {
    logic [1:0]            op;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [BW-1:0]         xlo;
    logic [BW-1:0]         xhi;
    logic [BW-1:0]         ylo;
    logic [BW-1:0]         yhi;
  } cmd_t;

  logic  held;
  cmd_t  held_cmd;
  cmd_t  cmd_next;
  logic  accept;

  logic signed [BW-1:0] x_ext;
  logic signed [BW-1:0] y_ext;
  logic signed [BW-1:0] r_ext;

  assign x_ext = {{BOUND_GUARD_BITS{x_coord[COORD_BITS-1]}}, x_coord};
  assign y_ext = {{BOUND_GUARD_BITS{y_coord[COORD_BITS-1]}}, y_coord};
  assign r_ext = {{(BOUND_GUARD_BITS+1){1'b0}}, search_range};

  always_comb begin
    cmd_next.op  = opcode;
    cmd_next.x   = x_coord;
    cmd_next.y   = y_coord;
    cmd_next.xlo = x_ext - r_ext;
    cmd_next.xhi = x_ext + r_ext;
    cmd_next.ylo = y_ext - r_ext;
    cmd_next.yhi = y_ext + r_ext;
  end

  // The held item drains into the queue whenever the queue has room.
  assign busy   = held && queue_full;
  assign accept = start && !busy;
  assign push   = held && !queue_full;
  assign cmd    = held_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (!queue_full) begin
      held <= 1'b0;
    end
    if (accept) begin
      held_cmd <= cmd_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/opt_fifo.sv @@
`default_nettype none

module opt_fifo #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty,
  output logic                  full
);

  // Two-entry queue between the front and the back.
  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign empty = (fill == 2'd0);
  assign full  = (fill == 2'd2);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= !rd_ptr;
      end
      if ((push && !full) && !(pop && !empty)) begin
        fill <= fill + 2'd1;
      end else if (!(push && !full) && (pop && !empty)) begin
        fill <= fill - 2'd1;
      end
    end
    if (push && !full) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

@@ rtl/opt_back.sv @@
`default_nettype none

module opt_back import opt_pkg::*; #(
  parameter int TABLE_ENTRIES = 64,
  parameter int COORD_BITS    = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic queue_empty,
  input  wire logic [2+2*COORD_BITS+4*(COORD_BITS+BOUND_GUARD_BITS)-1:0] cmd,
  output logic      pop,
  output logic      done,
  output logic [1:0] status
);

  localparam int BW = COORD_BITS + BOUND_GUARD_BITS;
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX   = IW'(TABLE_ENTRIES - 1);

  typedef struct packed {
    logic [1:0]            op;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [BW-1:0]         xlo;
    logic [BW-1:0]         xhi;
    logic [BW-1:0]         ylo;
    logic [BW-1:0]         yhi;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_SCAN
  } state_t;

  state_t  state;
  cmd_t    in_cmd;
  cmd_t    cur;
  logic [IW-1:0] scan_idx;
  logic [IW-1:0] pend_idx;
  logic          rd_pend;
  logic          issuing;
  logic          slot_valid [TABLE_ENTRIES];
  logic [CW-1:0] entry_count;

  logic                    ram_we;
  logic [2*COORD_BITS-1:0] ram_rdata;
  logic [COORD_BITS-1:0]   px;
  logic [COORD_BITS-1:0]   py;
  logic signed [BW-1:0]    px_ext;
  logic signed [BW-1:0]    py_ext;
  logic                    exact_hit;
  logic                    box_hit;
  logic                    hit;

  assign in_cmd = cmd_t'(cmd);
  assign pop    = (state == S_IDLE) && !queue_empty;

  // Points are stored as {x, y} in one word.
  assign ram_we = (state == S_INSERT) && !slot_valid[scan_idx];

  opt_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (TABLE_ENTRIES)
  ) u_points (
    .clk   (clk),
    .we    (ram_we),
    .waddr (scan_idx),
    .wdata ({cur.x, cur.y}),
    .raddr (scan_idx),
    .rdata (ram_rdata)
  );

  assign px     = ram_rdata[2*COORD_BITS-1:COORD_BITS];
  assign py     = ram_rdata[COORD_BITS-1:0];
  assign px_ext = {{BOUND_GUARD_BITS{px[COORD_BITS-1]}}, px};
  assign py_ext = {{BOUND_GUARD_BITS{py[COORD_BITS-1]}}, py};

  assign exact_hit = (px == cur.x) && (py == cur.y);
  assign box_hit   = (px_ext >= $signed(cur.xlo)) && (px_ext <= $signed(cur.xhi)) &&
                     (py_ext >= $signed(cur.ylo)) && (py_ext <= $signed(cur.yhi));
  assign hit = rd_pend && slot_valid[pend_idx] &&
               ((cur.op == OP_DELETE) ? exact_hit : box_hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      done        <= 1'b0;
      rd_pend     <= 1'b0;
      issuing     <= 1'b0;
      entry_count <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        slot_valid[i] <= 1'b0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!queue_empty) begin
            cur      <= in_cmd;
            scan_idx <= '0;
            rd_pend  <= 1'b0;
            issuing  <= 1'b1;
            case (in_cmd.op)
              OP_INSERT: begin
                if (entry_count == FULL_COUNT) begin
                  done   <= 1'b1;
                  status <= ST_FULL;
                end else begin
                  state <= S_INSERT;
                end
              end
              OP_DELETE, OP_QUERY: begin
                if (entry_count == '0) begin
                  done   <= 1'b1;
                  status <= ST_EMPTY;
                end else begin
                  state <= S_SCAN;
                end
              end
              default: begin
                done   <= 1'b1;
                status <= ST_NO_MATCH;
              end
            endcase
          end
        end
        S_INSERT: begin
          // A free slot exists, so the walk ends before the last index is passed.
          if (!slot_valid[scan_idx]) begin
            slot_valid[scan_idx] <= 1'b1;
            entry_count          <= entry_count + CW'(1);
            done                 <= 1'b1;
            status               <= ST_DONE;
            state                <= S_IDLE;
          end else begin
            scan_idx <= scan_idx + IW'(1);
          end
        end
        S_SCAN: begin
          // One read is issued per cycle; its data is checked the cycle after.
          if (issuing) begin
            pend_idx <= scan_idx;
            rd_pend  <= 1'b1;
            if (scan_idx == LAST_IDX) begin
              issuing <= 1'b0;
            end else begin
              scan_idx <= scan_idx + IW'(1);
            end
          end else begin
            rd_pend <= 1'b0;
          end
          if (hit) begin
            if (cur.op == OP_DELETE) begin
              slot_valid[pend_idx] <= 1'b0;
              entry_count          <= entry_count - CW'(1);
            end
            done    <= 1'b1;
            status  <= ST_DONE;
            state   <= S_IDLE;
            rd_pend <= 1'b0;
          end else if (rd_pend && (pend_idx == LAST_IDX)) begin
            done    <= 1'b1;
            status  <= ST_NO_MATCH;
            state   <= S_IDLE;
            rd_pend <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
